[src/lsp_pkg.sv]
// Shared types and constants for the LIFO stack with peek.
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

  // Default geometry of the stack.
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 8;

  // Fixed field widths of the beats on the two channels.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Action codes carried by an input beat.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Status codes carried by a result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

endpackage

`default_nettype wire

[src/lsp_in_if.sv]
// Input channel of the LIFO stack: one action per beat.
`timescale 1ns / 1ps
`default_nettype none

interface lsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [lsp_pkg::ACTION_W-1:0] action;
  logic [lsp_pkg::BYTE_W-1:0]   push_value;
  logic [lsp_pkg::POS_W-1:0]    position;

  modport source (output valid, output action, output push_value, output position,
                  input ready);
  modport sink (input valid, input action, input push_value, input position,
                output ready);
endinterface

`default_nettype wire

[src/lsp_out_if.sv]
// Result channel of the LIFO stack: one result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface lsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [lsp_pkg::BYTE_W-1:0]   data_out;
  logic [lsp_pkg::STATUS_W-1:0] status;
  logic                         is_empty;
  logic                         is_full;
  logic [lsp_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output data_out, output status, output is_empty,
                  output is_full, output entry_count, input ready);
  modport sink (input valid, input data_out, input status, input is_empty,
                input is_full, input entry_count, output ready);
endinterface

`default_nettype wire

[src/lifo_stack_with_peek.sv]
// Top level of the LIFO stack with peek: entry memory, fill counter and result stages.
// Path: an accepted action is registered in stage A alongside the synchronous memory
//   read, and its result beat then moves on into the output register.
// Throughput: one action per cycle; the single memory port reads or writes one
//   entry per action, and the input stalls only while the output register is held.
// Reset: synchronous, active low; the fill count and all valid flags clear, the
//   entry memory keeps its contents, which are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_peek #(
  parameter int unsigned DEPTH = lsp_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = lsp_pkg::WIDTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  lsp_in_if.sink    in_ch,
  lsp_out_if.source out_ch
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > lsp_pkg::POS_W) ? CW : lsp_pkg::POS_W;

  // Entry memory with a registered read port.
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_rd_r;

  // Fill count and pipeline registers.
  logic [CW-1:0]            count_r, count_nxt;
  logic                     a_valid_r;
  logic                     a_rd_r;
  lsp_pkg::status_t         a_status_r;
  logic [CW-1:0]            a_count_r;
  logic                     out_valid_r;
  logic [lsp_pkg::BYTE_W-1:0]   out_data_r;
  lsp_pkg::status_t         out_status_r;
  logic [CW-1:0]            out_count_r;

  // Decode of the incoming action.
  lsp_pkg::action_t         act;
  logic                     accept;
  logic                     advance;
  logic                     is_full_now;
  logic                     is_empty_now;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [PW-1:0]            peek_idx;
  logic [CW-1:0]            pop_idx;
  logic                     pos_bad;
  logic                     wr_en;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  lsp_pkg::status_t         status_nxt;

  // Stage A moves on when the output register is free or being emptied.
  assign advance      = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  assign act          = lsp_pkg::action_t'(in_ch.action);
  assign is_full_now  = (count_r == CW'(DEPTH));
  assign is_empty_now = (count_r == '0);
  assign pos_ext      = PW'(in_ch.position);
  assign cnt_ext      = PW'(count_r);
  assign peek_idx     = cnt_ext - pos_ext;
  assign pop_idx      = count_r - CW'(1);
  assign pos_bad      = (pos_ext == '0) || (pos_ext > cnt_ext);

  // Work out the status, the new count and the memory access of one action.
  always_comb begin
    status_nxt = lsp_pkg::ST_OK;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = pop_idx[AW-1:0];
    case (act)
      lsp_pkg::ACT_PUSH: begin
        if (is_full_now) begin
          status_nxt = lsp_pkg::ST_OVERFLOW;
        end else begin
          wr_en     = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      lsp_pkg::ACT_POP: begin
        if (is_empty_now) begin
          status_nxt = lsp_pkg::ST_UNDERFLOW;
        end else begin
          rd_en     = 1'b1;
          count_nxt = pop_idx;
        end
      end
      lsp_pkg::ACT_PEEK: begin
        if (pos_bad) begin
          status_nxt = lsp_pkg::ST_BADPOS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = peek_idx[AW-1:0];
        end
      end
      default: begin
        status_nxt = lsp_pkg::ST_OK;
      end
    endcase
  end

  // Memory: one write or one read per accepted action; read data holds while stalled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= WIDTH'(in_ch.push_value);
    end
    if (accept && rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // Fill count and pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (advance) begin
        a_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of stage A and of the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_rd_r     <= rd_en;
      a_status_r <= status_nxt;
      a_count_r  <= count_nxt;
    end
    if (advance) begin
      out_data_r   <= a_rd_r ? lsp_pkg::BYTE_W'(mem_rd_r) : '0;
      out_status_r <= a_status_r;
      out_count_r  <= a_count_r;
    end
  end

  // Result beat.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.is_empty    = (out_count_r == '0);
  assign out_ch.is_full     = (out_count_r == CW'(DEPTH));
  assign out_ch.entry_count = lsp_pkg::COUNT_W'(out_count_r);

  // The fill count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // A successful push raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (act == lsp_pkg::ACT_PUSH) && !is_full_now |=>
      count_r == $past(count_r) + CW'(1))
    else $error("push did not advance the count");

  // An overflow is only reported on a full stack, an underflow on an empty one.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == lsp_pkg::ST_OVERFLOW) |-> out_ch.is_full)
    else $error("overflow on a stack that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == lsp_pkg::ST_UNDERFLOW) |-> out_ch.is_empty)
    else $error("underflow on a stack that is not empty");

  // A stage A item that cannot advance stays in place.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !advance |=> a_valid_r)
    else $error("stage A item lost while stalled");

endmodule

`default_nettype wire

[sim/lsp_result_checker.sv]
// Result checker for the LIFO stack: models the stack and compares every result beat.
`timescale 1ns / 1ps

module lsp_result_checker
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lsp_in_if           in_ch,
  lsp_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned checked_count,
  output int unsigned overflow_count,
  output int unsigned underflow_count,
  output int unsigned badpos_count
);

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;

  // One expected result beat, laid out like the result channel.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    status_t            status;
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] entry_count;
  } stack_result_t;

  // Shadow copy of the stack contents and its fill level.
  logic [BYTE_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_fill;
  stack_result_t     expected_results [$];

  // Applies one action to the shadow stack and returns the result it should give.
  function automatic stack_result_t next_stack_result(action_t act, logic [BYTE_W-1:0] value,
                                                      logic [POS_W-1:0] pos);
    stack_result_t r;
    r.data_out = '0;
    r.status   = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_mem[stack_fill] = value;
          stack_fill++;
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          stack_fill--;
          r.data_out = stack_mem[stack_fill];
        end
      end
      ACT_PEEK: begin
        // Position 1 is the top; anything outside 1..fill is rejected.
        if (pos == 0 || pos > stack_fill) begin
          r.status = ST_BADPOS;
        end else begin
          r.data_out = stack_mem[stack_fill - pos];
        end
      end
      default: begin
        // The spare action code leaves the stack alone and reports it as it is.
      end
    endcase
    r.is_empty    = (stack_fill == 0);
    r.is_full     = (stack_fill == STACK_DEPTH);
    r.entry_count = stack_fill[COUNT_W-1:0];
    return r;
  endfunction

  // Reports one field that differs and returns 1 for it.
  function automatic int unsigned field_mismatch(string name, logic [BYTE_W-1:0] want,
                                                 logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare result beats first, then record the action beat taken at the same edge.
  always @(posedge clk) begin
    stack_result_t want;
    int unsigned   bad;
    bad = 0;
    if (!rst_n) begin
      expected_results.delete();
      stack_fill      = 0;
      fail_count      <= 0;
      pending_count   <= 0;
      checked_count   <= 0;
      overflow_count  <= 0;
      underflow_count <= 0;
      badpos_count    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no action waiting for it");
          bad = 1;
        end else begin
          want = expected_results.pop_front();
          bad += field_mismatch("data_out", want.data_out, out_ch.data_out);
          bad += field_mismatch("status", want.status, out_ch.status);
          bad += field_mismatch("is_empty", want.is_empty, out_ch.is_empty);
          bad += field_mismatch("is_full", want.is_full, out_ch.is_full);
          bad += field_mismatch("entry_count", want.entry_count, out_ch.entry_count);
        end
        checked_count <= checked_count + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = next_stack_result(action_t'(in_ch.action), in_ch.push_value, in_ch.position);
        expected_results.push_back(want);
        if (want.status == ST_OVERFLOW) overflow_count <= overflow_count + 1;
        if (want.status == ST_UNDERFLOW) underflow_count <= underflow_count + 1;
        if (want.status == ST_BADPOS) badpos_count <= badpos_count + 1;
      end
      fail_count    <= fail_count + bad;
      pending_count <= expected_results.size();
    end
  end

endmodule

[sim/tb.sv]
// Testbench top for the LIFO stack: clock, reset, action stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module tb;
  import lsp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 525;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 60;

  logic clk = 1'b0;
  logic rst_n;

  lsp_in_if  in_ch ();
  lsp_out_if out_ch ();

  int unsigned fail_count, pending_count, checked_count;
  int unsigned overflow_count, underflow_count, badpos_count;
  int unsigned items_sent = 0;
  int unsigned depth_track = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_done = 1'b0;

  lifo_stack_with_peek dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lsp_result_checker u_results (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .overflow_count  (overflow_count),
    .underflow_count (underflow_count),
    .badpos_count    (badpos_count)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offers one action beat after an optional gap and waits until it is taken.
  task automatic offer_action(action_t act, logic [BYTE_W-1:0] value, logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.push_value <= value;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    // Track the fill level only to steer later stimulus.
    if (act == ACT_PUSH && depth_track < DEPTH_DEF) depth_track++;
    if (act == ACT_POP && depth_track > 0) depth_track--;
  endtask

  // Action stimulus and final verdict.
  initial begin
    int unsigned      mode, roll, push_w, pop_w;
    action_t          act;
    logic [POS_W-1:0] pos;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_PUSH;
    in_ch.push_value <= '0;
    in_ch.position   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: errors on the empty stack, fill to the top, overflow,
    // peeks at both ends and outside the range, then a pop from the full stack.
    offer_action(ACT_PEEK, 8'h00, 5'd1);
    offer_action(ACT_POP, 8'h00, 5'd0);
    offer_action(ACT_NONE, 8'hFF, 5'd31);
    offer_action(ACT_PUSH, 8'h00, 5'd0);
    offer_action(ACT_PUSH, 8'hFF, 5'd0);
    offer_action(ACT_PUSH, 8'hAA, 5'd0);
    offer_action(ACT_PUSH, 8'h55, 5'd0);
    for (int i = 4; i < DEPTH_DEF; i++) offer_action(ACT_PUSH, 8'(i * 17 + 3), 5'd0);
    offer_action(ACT_PUSH, 8'h77, 5'd0);
    offer_action(ACT_PEEK, 8'h00, 5'd16);
    offer_action(ACT_PEEK, 8'h00, 5'd17);
    offer_action(ACT_PEEK, 8'h00, 5'd0);
    offer_action(ACT_PEEK, 8'h00, 5'd31);
    offer_action(ACT_PEEK, 8'h00, 5'd1);
    offer_action(ACT_NONE, 8'h00, 5'd0);
    offer_action(ACT_POP, 8'h00, 5'd0);

    // Random part: phases that lean toward filling, draining or neither, so the
    // stack keeps running into both ends while peeks mostly land in range.
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       begin push_w = 70; pop_w = 12; end
        1:       begin push_w = 15; pop_w = 68; end
        default: begin push_w = 40; pop_w = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_w) act = ACT_PUSH;
      else if (roll < push_w + pop_w) act = ACT_POP;
      else if (roll < 97) act = ACT_PEEK;
      else act = ACT_NONE;
      if (depth_track > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(1, depth_track));
      else pos = POS_W'($urandom_range(0, 31));
      offer_action(act, BYTE_W'($urandom_range(0, 255)), pos);
    end
    in_ch.valid <= 1'b0;

    // Let the last results drain, then a little longer.
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d actions sent, %0d results checked.", items_sent, checked_count);
    $display("Errors exercised: %0d overflows, %0d underflows, %0d bad peek positions.",
             overflow_count, underflow_count, badpos_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result pacing: random ready with one long hold-off to back the block up.
  initial begin
    int unsigned roll;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      roll = $urandom_range(0, 99);
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (roll < 60) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (roll < 93) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles.", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

[filelist.f]
src/lsp_pkg.sv
src/lsp_in_if.sv
src/lsp_out_if.sv
src/lifo_stack_with_peek.sv
sim/lsp_result_checker.sv
sim/tb.sv
